/* sv/mrif_pkg.sv */
// Shared types and constants for the most-recent-instance finder.
// No dependencies; every other file imports this package.
package mrif_pkg;

    // Field widths fixed by the interface.
    localparam int SEQ_W      = 8;
    localparam int CNT_W      = 5;
    localparam int STAT_W     = 2;
    localparam int SLOT_OUT_W = 4;

    // Marker value of an invalid copy.
    localparam logic [SEQ_W-1:0] SEQ_INVALID = 8'hFF;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_NONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_ROLL  = 2'd2;

    // Control from the top level to the scan sequencer.
    typedef struct packed {
        logic             start;
        logic             ack;
        logic [CNT_W-1:0] count;
    } t_scan_ctl;

    // Status from the scan sequencer back to the top level.
    typedef struct packed {
        logic              busy;
        logic              done;
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  slot;
    } t_scan_res;

endpackage

/* sv/mrif_in_if.sv */
// Input channel: one sequence counter per item, valid/ready handshake.
// Depends on mrif_pkg for the field width.
interface mrif_in_if;
    import mrif_pkg::*;

    logic             valid;
    logic             ready;
    logic [SEQ_W-1:0] seq_value;

    modport source (output valid, output seq_value, input ready);
    modport sink   (input valid, input seq_value, output ready);
endinterface

/* sv/mrif_out_if.sv */
// Output channel: status and newest slot per item, valid/ready handshake.
// Depends on mrif_pkg for the field widths.
interface mrif_out_if;
    import mrif_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [STAT_W-1:0]     status;
    logic [SLOT_OUT_W-1:0] newest_slot;

    modport source (output valid, output status, output newest_slot, input ready);
    modport sink   (input valid, input status, input newest_slot, output ready);
endinterface

/* sv/mrif_store.sv */
// Counter store: one write port, one registered read port.
// Depends on mrif_pkg for widths.
module mrif_store #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [mrif_pkg::CNT_W-1:0] i_waddr,
    input  logic [mrif_pkg::SEQ_W-1:0] i_wdata,
    input  logic [mrif_pkg::CNT_W-1:0] i_raddr,
    output logic [mrif_pkg::SEQ_W-1:0] o_rdata
);
    import mrif_pkg::*;

    logic [SEQ_W-1:0] r_mem [DEPTH];
    logic [SEQ_W-1:0] r_rdata;

    // Resize slot indices to the memory address width.
    logic [CNT_W+ADDR_W-1:0] w_wext;
    logic [CNT_W+ADDR_W-1:0] w_rext;
    logic [ADDR_W-1:0]       w_waddr;
    logic [ADDR_W-1:0]       w_raddr;

    assign w_wext  = {{ADDR_W{1'b0}}, i_waddr};
    assign w_rext  = {{ADDR_W{1'b0}}, i_raddr};
    assign w_waddr = w_wext[ADDR_W-1:0];
    assign w_raddr = w_rext[ADDR_W-1:0];

    // Write port, guarded against slots beyond the depth.
    always_ff @(posedge i_clk) begin
        if (i_we && (32'(i_waddr) < DEPTH)) begin
            r_mem[w_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[w_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* sv/mrif_scan.sv */
// Scan sequencer with one shared compare/subtract step per cycle.
// Pass one tracks min, max and rollover edges; pass two searches the
// rollover region. Depends on mrif_pkg.
module mrif_scan (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  mrif_pkg::t_scan_ctl        i_ctl,
    input  logic [mrif_pkg::SEQ_W-1:0] i_rdata,
    output logic [mrif_pkg::CNT_W-1:0] o_raddr,
    output mrif_pkg::t_scan_res        o_res
);
    import mrif_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_P1   = 3'd1;
    localparam logic [2:0] S_DEC  = 3'd2;
    localparam logic [2:0] S_P2   = 3'd3;
    localparam logic [2:0] S_END  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]        r_state;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_idx;
    logic [CNT_W-1:0]  n_idx;
    logic [CNT_W:0]    r_cnt;
    logic [CNT_W:0]    r_total;
    logic              r_dv;
    logic [CNT_W-1:0]  r_didx;
    logic [SEQ_W-1:0]  r_last;
    logic [SEQ_W-1:0]  r_mn;
    logic [SEQ_W-1:0]  r_mx;
    logic [CNT_W-1:0]  r_mxs;
    logic              r_any;
    logic              r_hrs;
    logic              r_hre;
    logic [CNT_W-1:0]  r_rs;
    logic [CNT_W-1:0]  r_re;
    logic [SEQ_W-1:0]  r_best;
    logic              r_found;
    logic [CNT_W-1:0]  r_slot;
    logic [STAT_W-1:0] r_status;

    logic             w_issue;
    logic [CNT_W:0]   w_idx_inc;
    logic             w_valid;
    logic [SEQ_W-1:0] w_cnt8;
    logic [SEQ_W-1:0] w_spread;
    logic [CNT_W-1:0] w_len;

    // Read issue and circular slot advance.
    assign w_issue   = ((r_state == S_P1) || (r_state == S_P2)) && (r_cnt < r_total);
    assign w_idx_inc = {1'b0, r_idx} + 1'b1;
    assign n_idx     = (w_idx_inc >= {1'b0, r_count}) ? '0 : w_idx_inc[CNT_W-1:0];
    assign o_raddr   = r_idx;

    // Shared step operands.
    assign w_valid  = (i_rdata != SEQ_INVALID);
    assign w_cnt8   = SEQ_W'(r_count);
    assign w_spread = r_mx - r_mn;
    assign w_len    = (r_re > r_rs) ? (r_re - r_rs) : (r_count - (r_rs - r_re));

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dv    <= 1'b0;
        end else begin
            r_dv <= w_issue;
            unique case (r_state)
                S_IDLE: if (i_ctl.start) r_state <= S_P1;
                S_P1: begin
                    if (!w_issue && !r_dv) r_state <= S_DEC;
                end
                S_DEC: begin
                    if (r_any && (w_spread >= w_cnt8) && r_hrs && r_hre) r_state <= S_P2;
                    else r_state <= S_DONE;
                end
                S_P2: begin
                    if (!w_issue && !r_dv) r_state <= S_END;
                end
                S_END:  r_state <= S_DONE;
                S_DONE: if (i_ctl.ack) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath: one counter examined per cycle.
    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_idx  <= n_idx;
            r_cnt  <= r_cnt + 1'b1;
            r_didx <= r_idx;
        end
        case (r_state)
            S_IDLE: begin
                r_count <= i_ctl.count;
                r_idx   <= '0;
                r_cnt   <= '0;
                r_total <= {1'b0, i_ctl.count} + 1'b1;
                r_last  <= SEQ_INVALID;
                r_mn    <= SEQ_INVALID;
                r_mx    <= '0;
                r_mxs   <= '0;
                r_any   <= 1'b0;
                r_hrs   <= 1'b0;
                r_hre   <= 1'b0;
            end
            S_P1: begin
                if (r_dv && w_valid) begin
                    r_any <= 1'b1;
                    if (i_rdata < r_mn) r_mn <= i_rdata;
                    if (i_rdata >= r_mx) begin
                        r_mx  <= i_rdata;
                        r_mxs <= r_didx;
                    end
                    // Rollover start: big drop; rollover end: big rise.
                    if (!r_hrs && (i_rdata < r_last) && ((r_last - i_rdata) >= w_cnt8)) begin
                        r_hrs <= 1'b1;
                        r_rs  <= r_didx;
                    end else if (!r_hre && (i_rdata > r_last)
                                 && ((i_rdata - r_last) >= w_cnt8)) begin
                        r_hre <= 1'b1;
                        r_re  <= r_didx;
                    end
                    r_last <= i_rdata;
                end
            end
            S_DEC: begin
                r_idx   <= r_rs;
                r_cnt   <= '0;
                r_total <= {1'b0, w_len};
                r_best  <= '0;
                r_found <= 1'b0;
                r_slot  <= '0;
                if (!r_any) begin
                    r_status <= ST_NONE;
                end else if (w_spread >= w_cnt8) begin
                    r_status <= ST_ROLL;
                end else begin
                    r_status <= ST_FOUND;
                    r_slot   <= r_mxs;
                end
            end
            S_P2: begin
                // Ties go to the later slot.
                if (r_dv && w_valid && (i_rdata >= r_best)) begin
                    r_best  <= i_rdata;
                    r_slot  <= r_didx;
                    r_found <= 1'b1;
                end
            end
            S_END: begin
                if (r_found) begin
                    r_status <= ST_FOUND;
                end else begin
                    r_status <= ST_ROLL;
                    r_slot   <= '0;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_res.busy   = (r_state != S_IDLE);
    assign o_res.done   = (r_state == S_DONE);
    assign o_res.status = r_status;
    assign o_res.slot   = r_slot;
endmodule

/* sv/most_recent_instance_finder.sv */
// Most-recent-instance finder: loads one counter per cycle while its input is
// ready. After the last of N loads, pass one and its decision run, the rollover
// pass over len slots (len <= N) follows when needed, and the result register
// loads once it is free to take the scan result.
// Input is not ready while a scan runs; results wait in a register.
// Synchronous active-low reset clears control state; the store is not cleared.
module most_recent_instance_finder #(
    parameter int MAX_COPIES = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [mrif_pkg::CNT_W-1:0] i_cfg_wdata,
    mrif_in_if.sink                    i_item,
    mrif_out_if.source                 o_result
);
    import mrif_pkg::*;

    localparam int ADDR_W = (MAX_COPIES > 1) ? $clog2(MAX_COPIES) : 1;

    logic [CNT_W-1:0]      r_cfg;
    logic [CNT_W-1:0]      r_load_pos;
    logic [CNT_W-1:0]      n_load_pos;
    logic [CNT_W-1:0]      w_count;
    logic [CNT_W:0]        w_pos_inc;
    logic                  w_accept;
    logic                  w_last;
    logic                  w_out_free;
    logic                  r_out_valid;
    logic [STAT_W-1:0]     r_out_status;
    logic [SLOT_OUT_W-1:0] r_out_slot;
    logic [CNT_W-1:0]      w_raddr;
    logic [SEQ_W-1:0]      w_rdata;
    t_scan_ctl             w_ctl;
    t_scan_res             w_res;

    // Effective copy count: clamp to 1..MAX_COPIES.
    always_comb begin
        if (r_cfg == '0) w_count = CNT_W'(1);
        else if (32'(r_cfg) > MAX_COPIES) w_count = CNT_W'(MAX_COPIES);
        else w_count = r_cfg;
    end

    // Load sequencing.
    assign i_item.ready = !w_res.busy;
    assign w_accept     = i_item.valid && i_item.ready;
    assign w_pos_inc    = {1'b0, r_load_pos} + 1'b1;
    assign w_last       = (w_pos_inc >= {1'b0, w_count});
    assign n_load_pos   = w_last ? '0 : w_pos_inc[CNT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg      <= CNT_W'(16);
            r_load_pos <= '0;
        end else if (i_cfg_we) begin
            r_cfg      <= i_cfg_wdata;
            r_load_pos <= '0;
        end else if (w_accept) begin
            r_load_pos <= n_load_pos;
        end
    end

    mrif_store #(
        .DEPTH  (MAX_COPIES),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr (r_load_pos),
        .i_wdata (i_item.seq_value),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_out_free = !r_out_valid || o_result.ready;
    assign w_ctl.start = w_accept && w_last;
    assign w_ctl.ack   = w_res.done && w_out_free;
    assign w_ctl.count = w_count;

    mrif_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_rdata (w_rdata),
        .o_raddr (w_raddr),
        .o_res   (w_res)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.ack) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.ack) begin
            r_out_status <= w_res.status;
            r_out_slot   <= w_res.slot[SLOT_OUT_W-1:0];
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.status      = r_out_status;
    assign o_result.newest_slot = r_out_slot;

`ifndef SYNTHESIS
    // Load position never reaches the copy count.
    a_load_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_load_pos < w_count)
        else $error("load position out of range");

    // Slot is zero unless a copy was found.
    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && (o_result.status != ST_FOUND) |-> (o_result.newest_slot == '0))
        else $error("nonzero slot without found status");

    // Only defined status codes leave the block.
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.status == ST_NONE || o_result.status == ST_FOUND
                            || o_result.status == ST_ROLL))
        else $error("undefined status code");

    // A scan starts only from the last load of a round.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.start |=> w_res.busy && (r_load_pos == '0))
        else $error("scan did not start cleanly");
`endif
endmodule

/* bench/tb_most_recent_instance_finder.sv */
// Testbench for most_recent_instance_finder: drives rounds of sequence counters,
// predicts the newest slot per round and checks every result item in order.
// Depends on mrif_pkg, mrif_in_if, mrif_out_if and the block itself.
module tb_most_recent_instance_finder;
    timeunit 1ns;
    timeprecision 1ps;
    import mrif_pkg::*;

    localparam int MAX_COPIES    = 16;
    localparam int RANDOM_ITEMS  = 800;
    localparam int SETTLE_CYCLES = 60;
    localparam int CYCLE_LIMIT   = 500000;

    // Idle styles for either side of the block
    localparam int IDLE_NONE   = 0;
    localparam int IDLE_RANDOM = 1;
    localparam int IDLE_SPARSE = 2;

    typedef enum int {ROUND_SEQUENTIAL, ROUND_BROKEN, ROUND_NOISE, ROUND_EMPTY} t_round_kind;

    typedef struct {
        logic [STAT_W-1:0]     status;
        logic [SLOT_OUT_W-1:0] slot;
    } t_newest;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CNT_W-1:0] i_cfg_wdata;

    mrif_in_if  in_if ();
    mrif_out_if out_if ();

    most_recent_instance_finder #(.MAX_COPIES(MAX_COPIES)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (in_if),
        .o_result    (out_if)
    );

    // Shadow copy of the block's state
    logic [SEQ_W-1:0] model_store [MAX_COPIES] = '{default: '0};
    logic [4:0]       model_load_pos = '0;
    logic [CNT_W-1:0] model_copies   = 5'd16;

    t_newest          pending_results [$];
    logic [SEQ_W-1:0] round_vals [MAX_COPIES];
    int               items_sent  = 0;
    int               fail_count  = 0;
    int               cycle_count = 0;
    int               tx_idle     = IDLE_NONE;
    int               rx_idle     = IDLE_NONE;
    int               rx_stall    = 0;
    bit               rx_taken    = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int draw_wait(input int style);
        case (style)
            IDLE_RANDOM: return $urandom_range(0, 18);
            IDLE_SPARSE: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 18) : 0;
            default:     return 0;
        endcase
    endfunction

    function automatic int copies_effective();
        if (model_copies < 1) return 1;
        if (model_copies > MAX_COPIES) return MAX_COPIES;
        return model_copies;
    endfunction

    // Newest-slot search over the first n stored counters
    function automatic t_newest locate_newest(input int n);
        t_newest res;
        int      last, lo, hi, hi_slot, rs, re, idx, v, len, best, c;
        bit      any, has_rs, has_re, found;
        last = SEQ_INVALID;
        lo = 255;
        hi = 0;
        hi_slot = 0;
        rs = 0;
        re = 0;
        idx = 0;
        any = 0;
        has_rs = 0;
        has_re = 0;
        res.status = ST_NONE;
        res.slot = '0;
        // first pass: one lap plus one step, tracking bounds and wrap edges
        for (c = 0; c <= n; c++) begin
            v = model_store[idx];
            if (v != SEQ_INVALID) begin
                any = 1;
                if (v < lo) lo = v;
                if (v >= hi) begin
                    hi = v;
                    hi_slot = idx;
                end
                if (!has_rs && v < last && last - v >= n) begin
                    has_rs = 1;
                    rs = idx;
                end else if (!has_re && v > last && v - last >= n) begin
                    has_re = 1;
                    re = idx;
                end
                last = v;
            end
            idx = (idx + 1 >= n) ? 0 : idx + 1;
        end
        if (!any) return res;
        if (hi - lo < n) begin
            res.status = ST_FOUND;
            res.slot = SLOT_OUT_W'(hi_slot);
            return res;
        end
        if (!has_rs || !has_re) begin
            res.status = ST_ROLL;
            return res;
        end
        // second pass: largest counter inside the wrapped region, later slot on ties
        len = (re > rs) ? re - rs : n - (rs - re);
        best = 0;
        found = 0;
        idx = rs;
        for (c = 0; c < len; c++) begin
            v = model_store[idx];
            if (v != SEQ_INVALID && v >= best) begin
                best = v;
                res.slot = SLOT_OUT_W'(idx);
                found = 1;
            end
            idx = (idx + 1 >= n) ? 0 : idx + 1;
        end
        if (found) begin
            res.status = ST_FOUND;
        end else begin
            res.status = ST_ROLL;
            res.slot = '0;
        end
        return res;
    endfunction

    // Store one accepted counter; a full round queues its result
    function automatic void record_load(input logic [SEQ_W-1:0] value);
        int n;
        n = copies_effective();
        if (model_load_pos < MAX_COPIES) model_store[model_load_pos] = value;
        model_load_pos = model_load_pos + 1'b1;
        if (model_load_pos >= n) begin
            model_load_pos = '0;
            pending_results.push_back(locate_newest(n));
        end
    endfunction

    task automatic send_counter(input logic [SEQ_W-1:0] value);
        int gap;
        gap = draw_wait(tx_idle);
        @(negedge i_clk);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.seq_value <= value;
        do @(posedge i_clk); while (!in_if.ready);
        record_load(value);
        items_sent++;
    endtask

    task automatic hold_input();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
    endtask

    // Sender holds off until every queued result is back and the scan has settled
    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_copies(input logic [CNT_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        model_copies   = value;
        model_load_pos = '0;
    endtask

    // Fill round_vals with one round of n counters
    function automatic void build_round(input t_round_kind kind, input int n);
        int k, top, stride, gap_back, x, j;
        case (kind)
            ROUND_EMPTY: begin
                for (j = 0; j < n; j++) round_vals[j] = SEQ_INVALID;
            end
            ROUND_NOISE: begin
                top = $urandom_range(0, 255);
                for (j = 0; j < n; j++)
                    round_vals[j] = SEQ_W'($urandom_range(0, 1) ? $urandom_range(0, 255)
                                           : (top + $urandom_range(0, 3 * n)) % 256);
            end
            default: begin
                // round-robin writes ending at slot k, wrapping 254 -> 0
                k = $urandom_range(0, n - 1);
                top = ($urandom_range(0, 2) == 0) ? $urandom_range(0, n + 2)
                                                  : $urandom_range(0, 254);
                stride = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4) : 1;
                for (j = 0; j < n; j++) begin
                    gap_back = (k - j + n) % n;
                    x = top - gap_back * stride;
                    while (x < 0) x += 255;
                    round_vals[j] = SEQ_W'(x);
                end
                if ($urandom_range(0, 2) == 0)
                    repeat ($urandom_range(1, 3)) round_vals[$urandom_range(0, n - 1)] = SEQ_INVALID;
                if (kind == ROUND_BROKEN)
                    repeat ($urandom_range(1, 2))
                        round_vals[$urandom_range(0, n - 1)] = SEQ_W'($urandom_range(0, 254));
            end
        endcase
    endfunction

    task automatic send_round(input t_round_kind kind, input int n);
        build_round(kind, n);
        for (int j = 0; j < n; j++) send_counter(round_vals[j]);
    endtask

    function automatic t_round_kind pick_kind();
        int r;
        r = $urandom_range(0, 19);
        if (r < 11) return ROUND_SEQUENTIAL;
        if (r < 15) return ROUND_BROKEN;
        if (r < 18) return ROUND_NOISE;
        return ROUND_EMPTY;
    endfunction

    function automatic logic [CNT_W-1:0] pick_copies();
        case ($urandom_range(0, 9))
            0:       return 5'd0;
            1:       return 5'd1;
            2:       return 5'd16;
            3:       return CNT_W'($urandom_range(17, 31));
            4:       return 5'd31;
            default: return CNT_W'($urandom_range(2, 15));
        endcase
    endfunction

    // Result side: ready drops for a drawn number of cycles after each item
    always @(negedge i_clk) begin
        if (rx_taken) rx_stall = draw_wait(rx_idle);
        if (rx_stall > 0) begin
            out_if.ready <= 1'b0;
            rx_stall = rx_stall - 1;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_newest exp_res;
        rx_taken <= i_rst_n && out_if.valid && out_if.ready;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result item: status %0d, newest_slot %0d",
                       out_if.status, out_if.newest_slot);
                fail_count++;
            end else begin
                exp_res = pending_results.pop_front();
                if (out_if.status !== exp_res.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           exp_res.status, out_if.status);
                    fail_count++;
                end
                if (out_if.newest_slot !== exp_res.slot) begin
                    $error("newest_slot mismatch: expected %0d, actual %0d",
                           exp_res.slot, out_if.newest_slot);
                    fail_count++;
                end
            end
        end
    end

    // Reset count of 16 with counters wrapping past 254
    task automatic test_reset_default();
        tx_idle = IDLE_RANDOM;
        rx_idle = IDLE_RANDOM;
        for (int j = 0; j < MAX_COPIES; j++) send_counter(SEQ_W'((j + 250) % 255));
    endtask

    // Count of zero acts as one; field extremes and alternating bits
    task automatic test_single_copy_extremes();
        hold_input();
        wait_drained();
        write_copies(5'd0);
        send_counter(8'h00);
        send_counter(SEQ_INVALID);
        send_counter(8'hAA);
        send_counter(8'h55);
    endtask

    // Two copies: rollover across 254 -> 0, equal counters, both invalid
    task automatic test_rollover_pairs();
        hold_input();
        wait_drained();
        write_copies(5'd2);
        send_counter(8'd0);
        send_counter(8'd254);
        send_counter(8'd5);
        send_counter(8'd5);
        send_counter(SEQ_INVALID);
        send_counter(SEQ_INVALID);
    endtask

    // Wide spread with no rising wrap edge seen
    task automatic test_inconsistent_rollover();
        hold_input();
        wait_drained();
        write_copies(5'd3);
        send_counter(SEQ_INVALID);
        send_counter(8'd100);
        send_counter(8'd0);
    endtask

    // Phases of random rounds, each under a new count and idle style
    task automatic test_random_rounds();
        int start, n, rounds, partial;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            hold_input();
            wait_drained();
            write_copies(pick_copies());
            n = copies_effective();
            tx_idle = $urandom_range(IDLE_NONE, IDLE_SPARSE);
            rx_idle = $urandom_range(IDLE_NONE, IDLE_SPARSE);
            rounds = $urandom_range(1, 6);
            repeat (rounds) send_round(pick_kind(), n);
            // leave a round partly loaded; the next count write restarts it
            if (n > 1 && $urandom_range(0, 3) == 0) begin
                partial = $urandom_range(1, n - 1);
                repeat (partial) send_counter(SEQ_W'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        in_if.valid     = 1'b0;
        in_if.seq_value = '0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        i_rst_n         = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_default();
        test_single_copy_extremes();
        test_rollover_pairs();
        test_inconsistent_rollover();
        test_random_rounds();

        hold_input();
        wait_drained();
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* most_recent_instance_finder.f */
sv/mrif_pkg.sv
sv/mrif_in_if.sv
sv/mrif_out_if.sv
sv/mrif_store.sv
sv/mrif_scan.sv
sv/most_recent_instance_finder.sv
bench/tb_most_recent_instance_finder.sv
